/* src/vrs_pkg.sv */
package vrs_pkg;

    localparam int SIDE_DEF = 8;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 8;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_Z_FWD = 3'd2,
        OP_Z_REV = 3'd3,
        OP_Y_FWD = 3'd4,
        OP_Y_REV = 3'd5,
        OP_X_FWD = 3'd6,
        OP_X_REV = 3'd7
    } op_t;

    // write and read requests to the frame memory
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_layer;
        logic [IDX_W-1:0]  wr_row;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_layer;
        logic [IDX_W-1:0]  rd_row;
    } mem_req_t;

endpackage

/* src/voxel_region_shift_top.sv */
// Voxel frame of SIDE x SIDE x SIDE bits kept as one byte per (layer, row) in a
// single-port-per-direction memory with a registered read. A byte write or byte
// read goes from acceptance through ST_FINISH to its result word. A shift walks
// the chosen bytes one per cycle through read, modify and write back: a z move
// covers (layers in range) x (rows in range) bytes, a y or x move covers
// (lines in range) x SIDE bytes, at most SIDE*SIDE. A new word is taken while
// the previous result still waits on m_ready. Every word gives exactly one
// result word.
module voxel_region_shift_top
    import vrs_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic [IDX_W-1:0]  s_range_a_low,
    input  logic [IDX_W-1:0]  s_range_b_low,
    input  logic [IDX_W-1:0]  s_range_a_high,
    input  logic [IDX_W-1:0]  s_range_b_high,
    input  logic [IDX_W-1:0]  s_layer_index,
    input  logic [IDX_W-1:0]  s_row_index,
    input  logic [DATA_W-1:0] s_write_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_byte
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rd_data;
    logic              res_ready;
    logic              res_done;
    logic [DATA_W-1:0] res_data;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_read_byte_reg;

    assign res_ready = !m_valid_reg || m_ready;

    vrs_seq #(
        .SIDE(SIDE)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_range_a_low  (s_range_a_low),
        .s_range_b_low  (s_range_b_low),
        .s_range_a_high (s_range_a_high),
        .s_range_b_high (s_range_b_high),
        .s_layer_index  (s_layer_index),
        .s_row_index    (s_row_index),
        .s_write_byte   (s_write_byte),
        .res_ready      (res_ready),
        .res_done       (res_done),
        .res_data       (res_data),
        .mem_req        (mem_req),
        .mem_rd_data    (mem_rd_data)
    );

    vrs_frame_mem #(
        .SIDE(SIDE)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // output register parts the result side from the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_done) begin
                m_valid_reg     <= 1'b1;
                m_read_byte_reg <= res_data;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_read_byte_reg;

endmodule

/* src/vrs_frame_mem.sv */
module vrs_frame_mem
    import vrs_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    localparam int LW    = $clog2(SIDE);
    localparam int AW    = 2 * LW;
    localparam int DEPTH = 1 << AW;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    assign wr_addr = {req.wr_layer[LW-1:0], req.wr_row[LW-1:0]};
    assign rd_addr = {req.rd_layer[LW-1:0], req.rd_row[LW-1:0]};

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* src/vrs_seq.sv */
module vrs_seq
    import vrs_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic [IDX_W-1:0]  s_range_a_low,
    input  logic [IDX_W-1:0]  s_range_b_low,
    input  logic [IDX_W-1:0]  s_range_a_high,
    input  logic [IDX_W-1:0]  s_range_b_high,
    input  logic [IDX_W-1:0]  s_layer_index,
    input  logic [IDX_W-1:0]  s_row_index,
    input  logic [DATA_W-1:0] s_write_byte,
    input  logic              res_ready,
    output logic              res_done,
    output logic [DATA_W-1:0] res_data,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] mem_rd_data
);

    localparam logic [IDX_W-1:0] SIDE_MAX = IDX_W'(SIDE - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  o_reg, o_end_reg;
    logic [IDX_W-1:0]  n_reg, n_start_reg, n_end_reg;
    logic              down_reg;
    logic              zmode_reg;
    logic              ysel_reg;
    logic              fwd_reg;
    logic              first_reg;
    logic [DATA_W-1:0] mask_reg;
    logic              pend_reg;
    logic              pend_first_reg;
    logic [IDX_W-1:0]  pend_layer_reg, pend_row_reg;
    logic [DATA_W-1:0] carry_reg;
    logic              is_read_reg;

    op_t               op_in;
    logic [IDX_W-1:0]  ahc, bhc;
    logic              addr_ok;
    logic              accept;
    logic [IDX_W-1:0]  cur_layer, cur_row;
    logic [DATA_W-1:0] col_mask;
    logic [DATA_W-1:0] mask_y, mask_x;
    logic [DATA_W-1:0] carry_in;
    logic [DATA_W-1:0] new_val;

    assign op_in   = op_t'(s_req_type);
    assign ahc     = (s_range_a_high > SIDE_MAX) ? SIDE_MAX : s_range_a_high;
    assign bhc     = (s_range_b_high > SIDE_MAX) ? SIDE_MAX : s_range_b_high;
    assign addr_ok = (s_layer_index <= SIDE_MAX) && (s_row_index <= SIDE_MAX);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // column bit masks for y moves (bound b) and x moves (bound a)
    always_comb begin
        for (int c = 0; c < DATA_W; c++) begin
            col_mask[c] = (c < SIDE);
            mask_y[c]   = (c < SIDE) && (IDX_W'(c) >= s_range_b_low) && (IDX_W'(c) <= bhc);
            mask_x[c]   = (c < SIDE) && (IDX_W'(c) >= s_range_a_low) && (IDX_W'(c) <= ahc);
        end
    end

    assign cur_layer = ysel_reg ? n_reg : o_reg;
    assign cur_row   = ysel_reg ? o_reg : n_reg;

    // first word of a sweep takes cleared bits in
    assign carry_in = pend_first_reg ? '0 : carry_reg;

    always_comb begin
        if (zmode_reg) begin
            new_val = fwd_reg ? ((mem_rd_data << 1) & col_mask) : (mem_rd_data >> 1);
        end else begin
            new_val = (mem_rd_data & ~mask_reg) | (carry_in & mask_reg);
        end
    end

    always_comb begin
        mem_req = '0;
        if (pend_reg) begin
            mem_req.wr_en    = 1'b1;
            mem_req.wr_layer = pend_layer_reg;
            mem_req.wr_row   = pend_row_reg;
            mem_req.wr_data  = new_val;
        end else if (accept && op_in == OP_WRITE && addr_ok) begin
            mem_req.wr_en    = 1'b1;
            mem_req.wr_layer = s_layer_index;
            mem_req.wr_row   = s_row_index;
            mem_req.wr_data  = s_write_byte & col_mask;
        end
        if (state_reg == ST_RUN) begin
            mem_req.rd_en    = 1'b1;
            mem_req.rd_layer = cur_layer;
            mem_req.rd_row   = cur_row;
        end else if (accept && op_in == OP_READ && addr_ok) begin
            mem_req.rd_en    = 1'b1;
            mem_req.rd_layer = s_layer_index;
            mem_req.rd_row   = s_row_index;
        end
    end

    assign res_done = (state_reg == ST_FINISH) && res_ready;
    assign res_data = is_read_reg ? mem_rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            is_read_reg <= 1'b0;
        end else begin
            pend_reg <= 1'b0;
            if (pend_reg) begin
                carry_reg <= mem_rd_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        is_read_reg <= 1'b0;
                        first_reg   <= 1'b1;
                        fwd_reg     <= ~s_req_type[0];
                        state_reg   <= ST_FINISH;
                        unique case (op_in)
                            OP_WRITE: begin
                            end
                            OP_READ: begin
                                is_read_reg <= addr_ok;
                            end
                            OP_Z_FWD, OP_Z_REV: begin
                                zmode_reg   <= 1'b1;
                                ysel_reg    <= 1'b0;
                                down_reg    <= 1'b0;
                                o_reg       <= s_range_a_low;
                                o_end_reg   <= ahc;
                                n_reg       <= s_range_b_low;
                                n_start_reg <= s_range_b_low;
                                n_end_reg   <= bhc;
                                if (s_range_a_low <= ahc && s_range_b_low <= bhc) begin
                                    state_reg <= ST_RUN;
                                end
                            end
                            OP_Y_FWD, OP_Y_REV: begin
                                zmode_reg   <= 1'b0;
                                ysel_reg    <= 1'b1;
                                down_reg    <= s_req_type[0];
                                mask_reg    <= mask_y;
                                o_reg       <= s_range_a_low;
                                o_end_reg   <= ahc;
                                n_reg       <= s_req_type[0] ? SIDE_MAX : '0;
                                n_start_reg <= s_req_type[0] ? SIDE_MAX : '0;
                                n_end_reg   <= s_req_type[0] ? '0 : SIDE_MAX;
                                if (s_range_a_low <= ahc) begin
                                    state_reg <= ST_RUN;
                                end
                            end
                            OP_X_FWD, OP_X_REV: begin
                                zmode_reg   <= 1'b0;
                                ysel_reg    <= 1'b0;
                                down_reg    <= s_req_type[0];
                                mask_reg    <= mask_x;
                                o_reg       <= s_range_b_low;
                                o_end_reg   <= bhc;
                                n_reg       <= s_req_type[0] ? SIDE_MAX : '0;
                                n_start_reg <= s_req_type[0] ? SIDE_MAX : '0;
                                n_end_reg   <= s_req_type[0] ? '0 : SIDE_MAX;
                                if (s_range_b_low <= bhc) begin
                                    state_reg <= ST_RUN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    // read issued this cycle, written back next cycle
                    pend_reg       <= 1'b1;
                    pend_first_reg <= first_reg;
                    pend_layer_reg <= cur_layer;
                    pend_row_reg   <= cur_row;
                    if (n_reg == n_end_reg) begin
                        first_reg <= 1'b1;
                        n_reg     <= n_start_reg;
                        if (o_reg == o_end_reg) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            o_reg <= o_reg + 1'b1;
                        end
                    end else begin
                        first_reg <= 1'b0;
                        n_reg     <= down_reg ? (n_reg - 1'b1) : (n_reg + 1'b1);
                    end
                end
                ST_FINISH: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
